>>> design/assert_macros.svh
// Assertion macros for the soil texture classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clk edge outside reset.
`define STC_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clk edge, reset included.
`define STC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/stc_pkg.sv
// Types, codes and the quartz table of the soil texture classifier.
`timescale 1ns / 1ps
package stc_pkg;

  localparam int unsigned PCT_W   = 14;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned QTZ_W   = 7;
  localparam int unsigned RW_W    = 4;
  localparam int unsigned ERR_W   = 3;

  // 100 percent in hundredths of a percent.
  localparam logic [PCT_W-1:0] FULL_SCALE = 14'd10000;

  localparam logic [RW_W-1:0] RW_WET = 4'd15;
  localparam logic [RW_W-1:0] RW_DRY = 4'd5;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_SILT     = 3'd1,
    ERR_CLAY     = 3'd2,
    ERR_SAND     = 3'd3,
    ERR_NO_CLASS = 3'd4
  } stc_err_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_SAND            = 4'd0,
    CLS_LOAMY_SAND      = 4'd1,
    CLS_SANDY_LOAM      = 4'd2,
    CLS_LOAM            = 4'd3,
    CLS_SILT_LOAM       = 4'd4,
    CLS_SILT            = 4'd5,
    CLS_SANDY_CLAY_LOAM = 4'd6,
    CLS_CLAY_LOAM       = 4'd7,
    CLS_SILTY_CLAY_LOAM = 4'd8,
    CLS_SANDY_CLAY      = 4'd9,
    CLS_SILTY_CLAY      = 4'd10,
    CLS_CLAY            = 4'd11
  } stc_class_t;

  typedef struct packed {
    stc_class_t       texture_class;
    logic [QTZ_W-1:0] quartz;
    logic [RW_W-1:0]  residual_water;
    stc_err_t         error_code;
  } stc_result_t;

  // Quartz fraction per class in hundredths.
  function automatic logic [QTZ_W-1:0] quartz_of(input stc_class_t cls);
    logic [QTZ_W-1:0] q;
    unique case (cls)
      CLS_SAND:            q = 7'd92;
      CLS_LOAMY_SAND:      q = 7'd82;
      CLS_SANDY_LOAM:      q = 7'd60;
      CLS_LOAM:            q = 7'd40;
      CLS_SILT_LOAM:       q = 7'd25;
      CLS_SILT:            q = 7'd10;
      CLS_SANDY_CLAY_LOAM: q = 7'd60;
      CLS_CLAY_LOAM:       q = 7'd35;
      CLS_SILTY_CLAY_LOAM: q = 7'd10;
      CLS_SANDY_CLAY:      q = 7'd52;
      CLS_SILTY_CLAY:      q = 7'd10;
      CLS_CLAY:            q = 7'd25;
      default:             q = '0;
    endcase
    return q;
  endfunction

endpackage

>>> design/soil_texture_classifier.sv
// Top level of the soil texture classifier: input register, rules, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel  | direction | ports                                   | handshake
//  ---------+-----------+-----------------------------------------+--------------
//  in_      | consumer  | in_silt_pct, in_clay_pct                | valid / stall
//  out_     | producer  | out_texture_class, out_quartz_hundredths,| valid / stall
//           |           | out_residual_water_hundredths,          |
//           |           | out_error_code                          |
//
//  One word per cycle sustained while out_ does not stall; each word passes the input
//  register, then the rule chain, then the result register.
//  Reset (rst_n low, synchronous) empties both registers; no clearing pass.
//  A stall on out_ holds the result register; the input register keeps taking
//  words until it too is full, then in_stall rises in the same cycle.
//  No state survives from one word to the next.
module soil_texture_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stc_pkg::PCT_W-1:0]     in_silt_pct,
  input  logic [stc_pkg::PCT_W-1:0]     in_clay_pct,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stc_pkg::CLASS_W-1:0]   out_texture_class,
  output logic [stc_pkg::QTZ_W-1:0]     out_quartz_hundredths,
  output logic [stc_pkg::RW_W-1:0]      out_residual_water_hundredths,
  output logic [stc_pkg::ERR_W-1:0]     out_error_code
);
  import stc_pkg::*;

  // Input register stage.
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [PCT_W-1:0] s1_silt_r;
  logic [PCT_W-1:0] s1_clay_r;
  logic             s2_stall;
  logic             in_take;

  stc_result_t      cls_result;
  stc_result_t      out_result;

  // Stall the producer only when a word sits here and cannot move on.
  assign in_stall     = s1_valid_r && s2_stall;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the word; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_silt_r <= in_silt_pct;
      s1_clay_r <= in_clay_pct;
    end
  end

  // Range checks, sand derivation and the ordered texture rules.
  stc_classify u_classify (
    .silt   (s1_silt_r),
    .clay   (s1_clay_r),
    .result (cls_result)
  );

  // Result register toward the consumer.
  stc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r),
    .load_data  (cls_result),
    .load_stall (s2_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_result)
  );

  assign out_texture_class             = out_result.texture_class;
  assign out_quartz_hundredths         = out_result.quartz;
  assign out_residual_water_hundredths = out_result.residual_water;
  assign out_error_code                = out_result.error_code;

  // A rejected word leaves the class fields at their error values.
  `STC_ASSERT_CLK(a_err_fields,
    (out_valid && out_result.error_code != ERR_NONE) |->
      (out_result.texture_class == CLS_SAND && out_result.quartz == '0 &&
       out_result.residual_water == RW_DRY),
    "error result carries class data")
  // Every accepted class has a nonzero quartz fraction.
  `STC_ASSERT_CLK(a_ok_quartz,
    (out_valid && out_result.error_code == ERR_NONE) |-> (out_result.quartz != '0),
    "valid class with zero quartz")
  // Wet residual water only arises in the three sandiest classes.
  `STC_ASSERT_CLK(a_wet_sandy,
    (out_valid && out_result.residual_water == RW_WET) |->
      (out_result.texture_class == CLS_SAND ||
       out_result.texture_class == CLS_LOAMY_SAND ||
       out_result.texture_class == CLS_SANDY_LOAM),
    "wet residual outside sandy classes")
  // Back-pressure reaches the input only with both registers full.
  `STC_ASSERT_ALWAYS(a_stall_full,
    in_stall |-> (s1_valid_r && out_valid && out_stall),
    "input stalled with room in the pipeline")

endmodule

>>> design/stc_classify.sv
// Range checks and ordered texture rules for one silt/clay word.
`timescale 1ns / 1ps
module stc_classify (
  input  logic [stc_pkg::PCT_W-1:0] silt,
  input  logic [stc_pkg::PCT_W-1:0] clay,
  output stc_pkg::stc_result_t      result
);
  import stc_pkg::*;

  logic [PCT_W:0]   sum;
  logic [PCT_W-1:0] s;
  logic [PCT_W-1:0] c;
  logic [PCT_W-1:0] d;
  logic [16:0]      lin_sand;
  logic [16:0]      lin_lsand;
  stc_class_t       cls;
  logic             cls_ok;
  stc_err_t         err;

  assign s   = silt;
  assign c   = clay;
  assign sum = (PCT_W+1)'(s) + (PCT_W+1)'(c);
  // Sand; only meaningful when the sum stays within full scale.
  assign d   = PCT_W'((PCT_W+1)'(FULL_SCALE) - sum);

  assign lin_sand  = 17'({s, 1'b0}) + 17'({c, 1'b0}) + 17'(c);
  assign lin_lsand = 17'(s) + 17'({c, 1'b0});

  always_comb begin
    cls    = CLS_SAND;
    cls_ok = 1'b1;
    priority if (lin_sand < 17'd3000) begin
      cls = CLS_SAND;
    end else if (lin_lsand < 17'd3000) begin
      cls = CLS_LOAMY_SAND;
    end else if ((c >= 14'd700 && c <= 14'd2000 && d > 14'd5200) ||
                 (c < 14'd700 && s < 14'd5000)) begin
      cls = CLS_SANDY_LOAM;
    end else if (c >= 14'd700 && c <= 14'd2700 && s >= 14'd2800 &&
                 s < 14'd5000 && d <= 14'd5200) begin
      cls = CLS_LOAM;
    end else if ((s >= 14'd5000 && c >= 14'd1200 && c < 14'd2700) ||
                 (s >= 14'd5000 && s < 14'd8000 && c < 14'd1200)) begin
      cls = CLS_SILT_LOAM;
    end else if (s >= 14'd8000 && c < 14'd1200) begin
      cls = CLS_SILT;
    end else if (c >= 14'd2000 && c < 14'd3500 && s < 14'd2800 &&
                 d > 14'd4500) begin
      cls = CLS_SANDY_CLAY_LOAM;
    end else if (c >= 14'd2700 && c < 14'd4000 && d > 14'd2000 &&
                 d <= 14'd4500) begin
      cls = CLS_CLAY_LOAM;
    end else if (c >= 14'd2700 && c < 14'd4000 && d <= 14'd2000) begin
      cls = CLS_SILTY_CLAY_LOAM;
    end else if (c >= 14'd3500 && d > 14'd4500) begin
      cls = CLS_SANDY_CLAY;
    end else if (c >= 14'd4000 && s >= 14'd4000) begin
      cls = CLS_SILTY_CLAY;
    end else if (c >= 14'd4000 && d <= 14'd4500 && s < 14'd4000) begin
      cls = CLS_CLAY;
    end else begin
      cls_ok = 1'b0;
    end
  end

  always_comb begin
    priority if (s > FULL_SCALE) begin
      err = ERR_SILT;
    end else if (c > FULL_SCALE) begin
      err = ERR_CLAY;
    end else if (sum > (PCT_W+1)'(FULL_SCALE)) begin
      err = ERR_SAND;
    end else if (!cls_ok) begin
      err = ERR_NO_CLASS;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    if (err != ERR_NONE) begin
      result.texture_class  = CLS_SAND;
      result.quartz         = '0;
      result.residual_water = RW_DRY;
    end else begin
      result.texture_class  = cls;
      result.quartz         = quartz_of(cls);
      result.residual_water = (c < 14'd1800 && d > 14'd6500) ? RW_WET : RW_DRY;
    end
    result.error_code = err;
  end

endmodule

>>> design/stc_out_stage.sv
// Result register with valid/stall handshake toward the consumer.
`timescale 1ns / 1ps
module stc_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_valid,
  input  stc_pkg::stc_result_t load_data,
  output logic                 load_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stc_pkg::stc_result_t out_data
);
  import stc_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  stc_result_t data_r;
  logic        take;

  // Hold while a word waits and the consumer stalls.
  assign load_stall = valid_r && out_stall;
  assign take       = load_valid && !load_stall;
  assign valid_nxt  = load_stall ? 1'b1 : load_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
